// ----- sv/rcdb_pkg.sv -----
`default_nettype none
package rcdb_pkg;

  localparam int unsigned CanvasWidthDef  = 480;
  localparam int unsigned CanvasHeightDef = 480;

  localparam int unsigned CoordW = 12;
  localparam int unsigned CountW = 13;
  localparam int unsigned ColorW = 16;
  localparam int unsigned ReqW   = 16;
  // signed work width for clipping sums
  localparam int unsigned WorkW  = 18;

  typedef enum logic [1:0] {
    KIND_CLIPPED   = 2'd0,
    KIND_REJECTED  = 2'd1,
    KIND_PRESENTED = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_e;

  typedef enum logic {
    OP_FILL    = 1'b0,
    OP_PRESENT = 1'b1
  } op_e;

  typedef struct packed {
    logic [CountW-1:0]        top;
    logic signed [CountW-1:0] bottom;
  } band_t;

  typedef struct packed {
    logic [CountW-1:0] band_rows;
    logic [CoordW-1:0] band_top;
    logic [ColorW-1:0] out_color;
    logic [CountW-1:0] clip_h;
    logic [CountW-1:0] clip_w;
    logic [CoordW-1:0] clip_y;
    logic [CoordW-1:0] clip_x;
    kind_e             kind;
  } res_t;

  typedef struct packed {
    op_e                    op;
    logic signed [ReqW-1:0] rect_x;
    logic signed [ReqW-1:0] rect_y;
    logic signed [ReqW-1:0] rect_w;
    logic signed [ReqW-1:0] rect_h;
    logic [ColorW-1:0]      fill_color;
  } req_t;

endpackage
`default_nettype wire

// ----- sv/rcdb_clip.sv -----
`default_nettype none
module rcdb_clip #(
  parameter int unsigned CANVAS_WIDTH  = rcdb_pkg::CanvasWidthDef,
  parameter int unsigned CANVAS_HEIGHT = rcdb_pkg::CanvasHeightDef
) (
  input  wire logic           panel_ready_i,
  input  rcdb_pkg::req_t      req_i,
  input  rcdb_pkg::band_t     band_i,
  output rcdb_pkg::res_t      res_o,
  output logic                emit_o,
  output rcdb_pkg::band_t     band_o
);

  localparam int unsigned W = rcdb_pkg::WorkW;
  localparam logic signed [W-1:0] CwS = W'(CANVAS_WIDTH);
  localparam logic signed [W-1:0] ChS = W'(CANVAS_HEIGHT);

  logic signed [W-1:0] xs, ys, ws, hs;
  logic signed [W-1:0] xa, ya, wa, ha, wc, hc, bot;
  logic signed [W-1:0] top_s, bot_s;
  logic signed [rcdb_pkg::CountW:0] top_c, bot_c, rows;
  logic fill_ok, band_empty;

  assign xs = W'(req_i.rect_x);
  assign ys = W'(req_i.rect_y);
  assign ws = W'(req_i.rect_w);
  assign hs = W'(req_i.rect_h);

  assign top_s = $signed({{(W-rcdb_pkg::CountW){1'b0}}, band_i.top});
  assign bot_s = W'(band_i.bottom);
  assign top_c = $signed({1'b0, band_i.top});
  assign bot_c = {band_i.bottom[rcdb_pkg::CountW-1], band_i.bottom};
  assign band_empty = top_c > bot_c;
  assign rows = bot_c - top_c + (rcdb_pkg::CountW+1)'(1);

  always_comb begin
    xa = xs;
    wa = ws;
    if (xs < 0) begin
      wa = ws + xs;
      xa = '0;
    end
    ya = ys;
    ha = hs;
    if (ys < 0) begin
      ha = hs + ys;
      ya = '0;
    end
    wc = (xa + wa > CwS) ? CwS - xa : wa;
    hc = (ya + ha > ChS) ? ChS - ya : ha;
    bot = ya + hc - W'(1);
    fill_ok = panel_ready_i && (ws > 0) && (hs > 0) && (xa < CwS) && (ya < ChS)
              && (wc > 0) && (hc > 0);
  end

  always_comb begin
    res_o      = '0;
    res_o.kind = rcdb_pkg::KIND_REJECTED;
    emit_o     = 1'b1;
    band_o     = band_i;
    case (req_i.op)
      rcdb_pkg::OP_PRESENT: begin
        if (!panel_ready_i) begin
          emit_o = 1'b0;
        end else if (band_empty) begin
          res_o.kind = rcdb_pkg::KIND_EMPTY;
        end else begin
          res_o.kind      = rcdb_pkg::KIND_PRESENTED;
          res_o.band_top  = band_i.top[rcdb_pkg::CoordW-1:0];
          res_o.band_rows = rows[rcdb_pkg::CountW-1:0];
          band_o.top      = rcdb_pkg::CountW'(CANVAS_HEIGHT);
          band_o.bottom   = '1;
        end
      end
      rcdb_pkg::OP_FILL: begin
        if (fill_ok) begin
          res_o.kind      = rcdb_pkg::KIND_CLIPPED;
          res_o.clip_x    = xa[rcdb_pkg::CoordW-1:0];
          res_o.clip_y    = ya[rcdb_pkg::CoordW-1:0];
          res_o.clip_w    = wc[rcdb_pkg::CountW-1:0];
          res_o.clip_h    = hc[rcdb_pkg::CountW-1:0];
          res_o.out_color = req_i.fill_color;
          if (ya < top_s) band_o.top = ya[rcdb_pkg::CountW-1:0];
          if (bot > bot_s) band_o.bottom = bot[rcdb_pkg::CountW-1:0];
        end
      end
      default: begin
        emit_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/rect_clip_dirty_band_tracker.sv -----
// a transferred request is held in the request register, then its result in the result register
// throughput: one request per cycle when not stalled, set by the single clip and band-update stage
// a stalled master side holds the result register and backs up the request register
// reset: panel not ready, dirty band empty (top = canvas height, bottom = -1),
// both pipeline registers empty
`default_nettype none
module rect_clip_dirty_band_tracker #(
  parameter int unsigned CANVAS_WIDTH  = rcdb_pkg::CanvasWidthDef,
  parameter int unsigned CANVAS_HEIGHT = rcdb_pkg::CanvasHeightDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,     // panel_ready
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,   // rect_x, rect_y, rect_w, rect_h, fill_color
  input  wire logic        s_axis_tuser,   // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // clip_x, clip_y, clip_w, clip_h, out_color, band_top, band_rows, zero pad
  output logic [95:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser    // kind
);

  logic panel_ready_q;
  logic in_valid_q;
  rcdb_pkg::req_t  req_q;
  rcdb_pkg::band_t band_q, band_d;
  logic out_valid_q;
  rcdb_pkg::res_t  out_q, res;
  logic emit, advance, s_xfer;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_ready_q <= 1'b0;
    end else if (cfg_valid_i) begin
      panel_ready_q <= cfg_data_i;
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      req_q.op         <= rcdb_pkg::op_e'(s_axis_tuser);
      req_q.rect_x     <= s_axis_tdata[15:0];
      req_q.rect_y     <= s_axis_tdata[31:16];
      req_q.rect_w     <= s_axis_tdata[47:32];
      req_q.rect_h     <= s_axis_tdata[63:48];
      req_q.fill_color <= s_axis_tdata[79:64];
    end
  end

  rcdb_clip #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT)
  ) u_clip (
    .panel_ready_i(panel_ready_q),
    .req_i        (req_q),
    .band_i       (band_q),
    .res_o        (res),
    .emit_o       (emit),
    .band_o       (band_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q.top    <= rcdb_pkg::CountW'(CANVAS_HEIGHT);
      band_q.bottom <= '1;
    end else if (advance) begin
      band_q <= band_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {5'b0, out_q.band_rows, out_q.band_top, out_q.out_color,
                          out_q.clip_h, out_q.clip_w, out_q.clip_y, out_q.clip_x};

  // presenting a band leaves it empty for the next request
  a_present_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit && res.kind == rcdb_pkg::KIND_PRESENTED) |=>
      (band_q.top == rcdb_pkg::CountW'(CANVAS_HEIGHT) && band_q.bottom == '1))
    else $error("band not cleared after present");

  // a nonempty band lies inside the canvas
  a_band_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (band_q.bottom >= 0) |->
      (band_q.top <= band_q.bottom[rcdb_pkg::CountW-1:0] &&
       band_q.bottom < $signed((rcdb_pkg::CountW+1)'(CANVAS_HEIGHT))))
    else $error("dirty band out of canvas");

  // a clipped rectangle is never empty and stays within the canvas width
  a_clip_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.kind == rcdb_pkg::KIND_CLIPPED) |->
      (out_q.clip_w != '0 && out_q.clip_h != '0 &&
       32'(out_q.clip_x) + 32'(out_q.clip_w) <= CANVAS_WIDTH))
    else $error("clipped rectangle empty or off canvas");

  // a request held back by a stalled result stays in place
  a_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(req_q)))
    else $error("stalled request lost");

endmodule
`default_nettype wire
